FILE: src/klt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klt_pkg
// shared types and constants of the keyed liveness timeout table
// ----------------------------------------------------------------------------
package klt_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxBits    = 5;
  localparam int unsigned TimeBits   = 40;
  localparam int unsigned KeyBits    = 32;
  localparam int unsigned QDepth     = 2;

  localparam logic [15:0] CheckIntervalRst   = 16'd7500;
  localparam logic [19:0] VehicleTimeoutRst  = 20'd15000;
  localparam logic [19:0] StationTimeoutRst  = 20'd50000;
  localparam logic [41:0] RefreshMargin      = 42'd1000;

  typedef enum logic [2:0] {
    ACT_TOUCH_V  = 3'd0,
    ACT_TOUCH_S  = 3'd1,
    ACT_REMOVE_V = 3'd2,
    ACT_REMOVE_S = 3'd3,
    ACT_CHECK    = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    REG_INTERVAL = 2'd0,
    REG_VTIMEOUT = 2'd1,
    REG_STIMEOUT = 2'd2,
    REG_WATCHDOG = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    EV_VEHICLE = 2'd0,
    EV_STATION = 2'd1,
    EV_DROPPED = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    OP_TOUCH,
    OP_REMOVE,
    OP_SCAN,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // classified request between front and back
  typedef struct packed {
    op_e                 op;
    logic                stn;
    logic [KeyBits-1:0]  key;
    logic [TimeBits-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          ev;
    logic [KeyBits-1:0]  key;
    logic [TimeBits-1:0] age;
    logic                last;
  } res_t;

endpackage

FILE: src/klt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klt_front
// accepts requests, runs the check hold-off logic and queues table commands
// ----------------------------------------------------------------------------
module klt_front import klt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          action_i,
  input  logic [KeyBits-1:0]  key_i,
  input  logic [TimeBits-1:0] now_i,
  input  logic [15:0]         interval_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output cmd_t                cmd_o
);

  cmd_t             q_mem [QDepth];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic [TimeBits-1:0] last_q;
  logic             hold_q;
  logic [TimeBits:0] until_q;

  logic       push, pop, fwd;
  cmd_t       cmd;
  logic [41:0] diff;
  logic [16:0] thr;
  logic        late, held;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rp_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  // signed difference now - last check
  assign diff = {2'b00, now_i} - {2'b00, last_q};
  assign thr  = {1'b0, interval_i} + {2'b00, interval_i[15:1]};
  assign late = !diff[41] && (diff > {25'd0, thr});
  assign held = hold_q && (until_q > {1'b0, now_i});

  always_comb begin
    cmd.op  = OP_CLEAR;
    cmd.stn = action_i[0];
    cmd.key = key_i;
    cmd.now = now_i;
    fwd     = 1'b0;
    case (action_i)
      ACT_TOUCH_V, ACT_TOUCH_S: begin
        cmd.op = OP_TOUCH;
        fwd    = 1'b1;
      end
      ACT_REMOVE_V, ACT_REMOVE_S: begin
        cmd.op = OP_REMOVE;
        fwd    = 1'b1;
      end
      ACT_CHECK: begin
        cmd.op = OP_SCAN;
        fwd    = !late && !held;
      end
      ACT_CLEAR: begin
        fwd = 1'b1;
      end
      default: fwd = 1'b0;
    endcase
  end

  assign push = in_valid_i && in_ready_o && fwd;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      cnt_q   <= 2'd0;
      last_q  <= '0;
      hold_q  <= 1'b0;
      until_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (in_valid_i && in_ready_o && action_i == ACT_CHECK) begin
        last_q <= now_i;
        if (late) begin
          hold_q  <= 1'b1;
          until_q <= {1'b0, now_i} + {23'd0, thr, 1'b0};
        end else if (!held) begin
          hold_q <= 1'b0;
        end
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_late_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_CHECK && late |=> hold_q)
    else $error("late check did not arm hold-off");

endmodule

FILE: src/klt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klt_back
// table storage, parallel key match, slot-by-slot aging scan and result register
// ----------------------------------------------------------------------------
module klt_back import klt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  cmd_t                cmd_i,
  input  logic [19:0]         vto_i,
  input  logic [19:0]         sto_i,
  input  logic                wdog_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o
);

  logic [KeyBits-1:0]  vkey_q [TableDepth];
  logic [TimeBits-1:0] vstp_q [TableDepth];
  logic [KeyBits-1:0]  skey_q [TableDepth];
  logic [TimeBits-1:0] sstp_q [TableDepth];
  logic [TableDepth-1:0] vval_q, sval_q;

  state_e state_q, state_d;
  logic   tbl_q;
  logic [IdxBits-1:0] idx_q;
  logic [TimeBits-1:0] now_q;
  logic   pend_q;
  res_t   pres_q;
  logic   rv_q;
  res_t   res_q;

  // combinational match on the incoming command
  logic [TableDepth-1:0] cval, hit, fre;
  logic [IdxBits-1:0] hit_i, fre_i;
  logic               any_hit, any_fre;

  always_comb begin
    cval    = cmd_i.stn ? sval_q : vval_q;
    hit     = '0;
    for (int i = 0; i < TableDepth; i++) begin
      hit[i] = cval[i] && ((cmd_i.stn ? skey_q[i] : vkey_q[i]) == cmd_i.key);
    end
    fre     = ~cval;
    any_hit = |hit;
    any_fre = |fre;
    hit_i   = '0;
    fre_i   = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (hit[i]) hit_i = IdxBits'(i);
      if (fre[i]) fre_i = IdxBits'(i);
    end
  end

  // scan slot data
  logic [TimeBits-1:0] stp;
  logic [KeyBits-1:0]  skey;
  logic                sval;
  logic [41:0]         cutoff, refr, stp_eff;
  logic [TimeBits-1:0] refr_sat;
  logic                evict;

  always_comb begin
    sval   = tbl_q ? sval_q[idx_q] : vval_q[idx_q];
    stp    = tbl_q ? sstp_q[idx_q] : vstp_q[idx_q];
    skey   = tbl_q ? skey_q[idx_q] : vkey_q[idx_q];
    cutoff = {2'b00, now_q} - {22'd0, (tbl_q ? sto_i : vto_i)};
    refr   = cutoff + RefreshMargin;
    if (refr[41]) refr_sat = '0;
    else if (refr[40]) refr_sat = '1;
    else refr_sat = refr[TimeBits-1:0];
    stp_eff = wdog_i ? {2'b00, stp} : {2'b00, refr_sat};
    evict   = sval && !cutoff[41] && (stp_eff <= cutoff);
  end

  logic out_free;
  logic accept;
  logic scan_end;
  logic emit;

  assign out_free    = !rv_q || res_ready_i;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;
  assign scan_end    = tbl_q && (idx_q == IdxBits'(TableDepth - 1));

  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    accept      = 1'b0;
    emit        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = out_free;
        accept      = cmd_valid_i && out_free;
        if (accept && cmd_i.op == OP_SCAN) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!(evict && pend_q && !out_free)) begin
          if (scan_end) state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!pend_q || out_free) begin
          emit    = pend_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  logic scan_go;
  assign scan_go = (state_q == ST_SCAN) && !(evict && pend_q && !out_free);

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i.op == OP_TOUCH) begin
      if (any_hit || any_fre) begin
        if (cmd_i.stn) begin
          sstp_q[any_hit ? hit_i : fre_i] <= cmd_i.now;
          skey_q[any_hit ? hit_i : fre_i] <= cmd_i.key;
        end else begin
          vstp_q[any_hit ? hit_i : fre_i] <= cmd_i.now;
          vkey_q[any_hit ? hit_i : fre_i] <= cmd_i.key;
        end
      end
    end
    if (scan_go && sval && !wdog_i) begin
      if (tbl_q) sstp_q[idx_q] <= refr_sat;
      else vstp_q[idx_q] <= refr_sat;
    end
    if (accept) now_q <= cmd_i.now;
    if (scan_go && evict) begin
      pres_q.ev   <= tbl_q ? EV_STATION : EV_VEHICLE;
      pres_q.key  <= skey;
      pres_q.age  <= now_q - stp_eff[TimeBits-1:0];
      pres_q.last <= 1'b0;
    end
    if (out_free) begin
      if (accept && cmd_i.op == OP_TOUCH && !any_hit && !any_fre) begin
        res_q <= '{ev: EV_DROPPED, key: cmd_i.key, age: '0, last: 1'b1};
      end else if (scan_go && evict && pend_q) begin
        res_q <= pres_q;
      end else if (emit) begin
        res_q <= '{ev: pres_q.ev, key: pres_q.key, age: pres_q.age, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vval_q  <= '0;
      sval_q  <= '0;
      tbl_q   <= 1'b0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        tbl_q  <= 1'b0;
        idx_q  <= '0;
        pend_q <= 1'b0;
        case (cmd_i.op)
          OP_TOUCH: begin
            if (!any_hit && any_fre) begin
              if (cmd_i.stn) sval_q[fre_i] <= 1'b1;
              else vval_q[fre_i] <= 1'b1;
            end
          end
          OP_REMOVE: begin
            if (cmd_i.stn) sval_q <= sval_q & ~hit;
            else vval_q <= vval_q & ~hit;
          end
          OP_CLEAR: begin
            vval_q <= '0;
            sval_q <= '0;
          end
          default: ;
        endcase
      end
      if (scan_go) begin
        if (evict) begin
          pend_q <= 1'b1;
          if (tbl_q) sval_q[idx_q] <= 1'b0;
          else vval_q[idx_q] <= 1'b0;
        end
        if (idx_q == IdxBits'(TableDepth - 1)) begin
          idx_q <= '0;
          tbl_q <= 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (emit) pend_q <= 1'b0;
      if (out_free) begin
        rv_q <= (accept && cmd_i.op == OP_TOUCH && !any_hit && !any_fre)
             || (scan_go && evict && pend_q) || emit;
      end
    end
  end

  a_scan_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> !cmd_ready_o) else $error("command taken during scan");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && !res_ready_i |=> rv_q && $stable(res_q)) else $error("result lost");
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && !pend_q |=> state_q == ST_IDLE) else $error("emit stuck");

endmodule

FILE: src/keyed_liveness_timeout_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_liveness_timeout_table
// two keyed tables of last-seen stamps with aging eviction on check requests
// ----------------------------------------------------------------------------
// touch, remove, clear: taken by the table unit while idle, a drop result is offered
// in the cycle after its request is taken
// check: the table unit takes it, ages every slot of both tables in turn and then
// flushes the last result, stalling while a result waits
// a two-entry queue parts request intake from the table unit
// reset clears all valid bits, hold-off state and restores register defaults
module keyed_liveness_timeout_table import klt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // action[2:0], key[34:3], now_ms[74:35]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // event_res[1:0], evicted_key[33:2], age_ms[73:34]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i
);

  logic [15:0] interval_q;
  logic [19:0] vto_q, sto_q;
  logic        wdog_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= CheckIntervalRst;
      vto_q      <= VehicleTimeoutRst;
      sto_q      <= StationTimeoutRst;
      wdog_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_INTERVAL: interval_q <= cfg_data_i[15:0];
        REG_VTIMEOUT: vto_q      <= cfg_data_i;
        REG_STIMEOUT: sto_q      <= cfg_data_i;
        REG_WATCHDOG: wdog_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  klt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tdata[2:0]),
    .key_i       (s_axis_tdata[34:3]),
    .now_i       (s_axis_tdata[74:35]),
    .interval_i  (interval_q),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  klt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .vto_i       (vto_q),
    .sto_i       (sto_q),
    .wdog_i      (wdog_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {6'd0, res.age, res.key, res.ev};
  assign m_axis_tlast = res.last;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the keyed liveness timeout table: touches, removes, clears and
// checks are streamed in with random gaps and output stalls; a local copy of
// both tables predicts every eviction and drop, compared field by field
// ----------------------------------------------------------------------------
module tb_top;
  import klt_pkg::*;

  typedef struct packed {
    logic [1:0]  ev;
    logic [31:0] key;
    logic [39:0] age;
    logic        last;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;

  keyed_liveness_timeout_table u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predicted table contents
  logic [15:0] interval_q;
  logic [19:0] veh_tmo_q, stn_tmo_q;
  logic        wdog_q;
  logic        vld_q [2][TableDepth];
  logic [31:0] key_q [2][TableDepth];
  logic [39:0] stamp_q [2][TableDepth];
  logic [39:0] last_chk_q;
  logic        hold_q;
  logic [40:0] hold_until_q;

  outcome_t expected_q[$];
  int       n_fail = 0;
  bit       calm_tx = 0, calm_rx = 0;
  int       rx_hold = 0;
  logic [31:0] known_keys[$];

  function automatic void table_reset();
    interval_q = CheckIntervalRst; veh_tmo_q = VehicleTimeoutRst;
    stn_tmo_q = StationTimeoutRst; wdog_q = 1'b1;
    for (int t = 0; t < 2; t++)
      for (int i = 0; i < TableDepth; i++) vld_q[t][i] = 1'b0;
    last_chk_q = '0; hold_q = 1'b0; hold_until_q = '0;
  endfunction

  function automatic void age_scan(int t, longint now);
    longint cutoff, refresh;
    longint tmax;
    tmax = (longint'(1) << 40) - 1;
    cutoff = now - longint'(t ? stn_tmo_q : veh_tmo_q);
    refresh = cutoff + 1000;
    if (refresh < 0) refresh = 0;
    if (refresh > tmax) refresh = tmax;
    for (int i = 0; i < TableDepth; i++) begin
      if (vld_q[t][i]) begin
        if (!wdog_q) stamp_q[t][i] = refresh[39:0];
        if (longint'(stamp_q[t][i]) <= cutoff) begin
          expected_q.push_back('{ev: t ? EV_STATION : EV_VEHICLE, key: key_q[t][i],
                                 age: 40'(now - longint'(stamp_q[t][i])), last: 1'b0});
          vld_q[t][i] = 1'b0;
        end
      end
    end
  endfunction

  function automatic void predict_request(logic [2:0] act, logic [31:0] key, logic [39:0] now);
    int t, n0, hit;
    longint diff, thr;
    t = act[0];
    n0 = expected_q.size();
    case (act)
      ACT_TOUCH_V, ACT_TOUCH_S: begin
        hit = -1;
        for (int i = 0; i < TableDepth; i++)
          if (hit < 0 && vld_q[t][i] && key_q[t][i] == key) hit = i;
        if (hit < 0)
          for (int i = 0; i < TableDepth; i++)
            if (hit < 0 && !vld_q[t][i]) hit = i;
        if (hit < 0) expected_q.push_back('{ev: EV_DROPPED, key: key, age: '0, last: 1'b1});
        else begin
          vld_q[t][hit] = 1'b1; key_q[t][hit] = key; stamp_q[t][hit] = now;
        end
      end
      ACT_REMOVE_V, ACT_REMOVE_S:
        for (int i = 0; i < TableDepth; i++)
          if (vld_q[t][i] && key_q[t][i] == key) vld_q[t][i] = 1'b0;
      ACT_CHECK: begin
        diff = longint'(now) - longint'(last_chk_q);
        thr = interval_q + interval_q / 2;
        last_chk_q = now;
        if (diff > thr) begin
          hold_q = 1'b1; hold_until_q = 41'(now) + 41'(2 * thr);
        end else if (!(hold_q && hold_until_q > 41'(now))) begin
          hold_q = 1'b0;
          age_scan(0, now);
          age_scan(1, now);
          if (expected_q.size() > n0) expected_q[$].last = 1'b1;
        end
      end
      ACT_CLEAR:
        for (int i = 0; i < TableDepth; i++) begin
          vld_q[0][i] = 1'b0; vld_q[1][i] = 1'b0;
        end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [2:0] act, logic [31:0] key, logic [39:0] now);
    while (!calm_tx && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, now, key, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_request(act, key, now);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [19:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_INTERVAL: interval_q = val[15:0];
      REG_VTIMEOUT: veh_tmo_q = val;
      REG_STIMEOUT: stn_tmo_q = val;
      REG_WATCHDOG: wdog_q = val[0];
      default: ;
    endcase
  endtask

  // result receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata); n_fail++;
        end else begin
          outcome_t e;
          e = expected_q.pop_front();
          if (m_axis_tdata[1:0] !== e.ev) begin
            $error("event_res exp %0d got %0d", e.ev, m_axis_tdata[1:0]); n_fail++;
          end
          if (m_axis_tdata[33:2] !== e.key) begin
            $error("evicted_key exp %h got %h", e.key, m_axis_tdata[33:2]); n_fail++;
          end
          if (m_axis_tdata[73:34] !== e.age) begin
            $error("age_ms exp %0d got %0d", e.age, m_axis_tdata[73:34]); n_fail++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last exp %0d got %0d", e.last, m_axis_tlast); n_fail++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= calm_rx || ($urandom_range(99) >= 37);
    end
  end

  function automatic logic [31:0] pick_key();
    if (known_keys.size() > 0 && $urandom_range(3) != 0)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    pick_key = $urandom();
    known_keys.push_back(pick_key);
    if (known_keys.size() > 48) void'(known_keys.pop_front());
  endfunction

  logic [39:0] clock_ms = 40'd1000;

  task automatic test_directed();
    send_request(ACT_TOUCH_V, 32'h0, 40'd0);
    send_request(ACT_TOUCH_V, 32'hFFFF_FFFF, 40'd100);
    send_request(ACT_TOUCH_S, 32'hA5A5_5A5A, 40'd200);
    send_request(ACT_CHECK, '0, 40'd20000);          // too late: arms hold-off
    send_request(ACT_CHECK, '0, 40'd25000);          // inside hold-off
    send_request(ACT_CHECK, '0, 40'd36000);          // still inside hold-off
    send_request(ACT_CHECK, '0, 40'd44000);          // hold-off over, evicts
    send_request(ACT_REMOVE_V, 32'h1234, 40'd0);     // absent key
    send_request(3'd6, 32'h1, 40'd0);
    send_request(3'd7, 32'h2, 40'd0);
    for (int i = 0; i < 33; i++) send_request(ACT_TOUCH_S, 32'h100 + i, 40'd64000);
    send_request(ACT_REMOVE_S, 32'h100, 40'd64000);
    send_request(ACT_CHECK, '0, 40'd60000);          // time going backwards
    send_request(ACT_CLEAR, '0, 40'hFF_FFFF_FFFF);
    send_request(ACT_TOUCH_V, 32'h77, 40'hFF_FFFF_FFF0);
    drain();
    last_chk_q = last_chk_q;
  endtask

  task automatic test_refresh();
    write_reg(REG_WATCHDOG, 20'd0);
    write_reg(REG_VTIMEOUT, 20'd0);
    write_reg(REG_INTERVAL, 20'd1);
    send_request(ACT_CHECK, '0, 40'hFF_FFFF_FFF6);   // late: short hold-off
    send_request(ACT_CHECK, '0, 40'hFF_FFFF_FFF7);   // inside hold-off
    send_request(ACT_CHECK, '0, 40'hFF_FFFF_FFF8);   // refresh saturates high
    send_request(ACT_TOUCH_V, 32'h9, 40'd5);
    send_request(ACT_TOUCH_S, 32'h5, 40'd5);
    send_request(ACT_CHECK, '0, 40'd10);             // refresh clamps at zero
    drain();
    write_reg(REG_WATCHDOG, 20'd1);
    write_reg(REG_VTIMEOUT, 20'hFFFFF);
    write_reg(REG_STIMEOUT, 20'd0);
    write_reg(REG_INTERVAL, 20'hFFFF);
    send_request(ACT_CHECK, '0, 40'd20);
    drain();
  endtask

  task automatic random_phase(int n_items, logic [15:0] intv);
    logic [2:0] a;
    write_reg(REG_INTERVAL, {4'd0, (intv == 0 ? 16'd1 : intv)});
    write_reg(REG_VTIMEOUT, 20'($urandom_range(3 * intv)));
    write_reg(REG_STIMEOUT, 20'($urandom_range(5 * intv)));
    write_reg(REG_WATCHDOG, 20'($urandom_range(3) != 0));
    for (int k = 0; k < n_items; k++) begin
      a = $urandom_range(99) < 55 ? 3'($urandom_range(1)) :
          $urandom_range(99) < 60 ? 3'(ACT_CHECK) : 3'($urandom_range(7));
      if ($urandom_range(50) == 0) clock_ms = 40'($urandom());
      else if ($urandom_range(30) == 0) clock_ms = clock_ms - 40'($urandom_range(intv));
      else clock_ms = clock_ms + 40'($urandom_range(intv / 4 + 1));
      send_request(a, a == ACT_CHECK ? 32'($urandom()) : pick_key(), clock_ms);
    end
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(REG_WATCHDOG, 20'd1);
    write_reg(REG_VTIMEOUT, 20'd0);
    write_reg(REG_STIMEOUT, 20'd0);
    write_reg(REG_INTERVAL, 20'hFFFF);
    rx_hold = 300;
    for (int i = 0; i < 8; i++) begin
      send_request(ACT_TOUCH_V, 32'hB00 + i, clock_ms);
      send_request(ACT_CHECK, '0, clock_ms);
    end
    drain();
  endtask

  initial begin
    table_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_refresh();
    test_backpressure();
    calm_tx = 1; calm_rx = 1;
    random_phase(50, 16'd200);
    calm_tx = 0; calm_rx = 0;
    random_phase(80, 16'd1);
    random_phase(80, 16'd3000);
    random_phase(70, 16'hFFFF);
    if (n_fail == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
